/* design/contact_gated_pi_force_control_top_assert.svh */
// assertion macros for the contact gated pi force controller
`ifndef CONTACT_GATED_PI_FORCE_CONTROL_TOP_ASSERT_SVH
`define CONTACT_GATED_PI_FORCE_CONTROL_TOP_ASSERT_SVH

// implication checked every clock outside reset
`define CGPI_ASSERT_IMP(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// next-cycle implication checked every clock outside reset
`define CGPI_ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

/* design/cgpi_pkg.sv */
// ----------------------------------------------------------------------------
// cgpi_pkg
// shared types and codes of the contact gated pi force controller
// ----------------------------------------------------------------------------
`default_nettype none
package cgpi_pkg;
   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_RESTART  = 2'd1;
   localparam logic [1:0] OP_MARK     = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_GOT  = 2'd1;
   localparam logic [1:0] MODE_IN   = 2'd2;

   localparam logic [2:0] REG_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_TARGET    = 3'd1;
   localparam logic [2:0] REG_ILIMIT    = 3'd2;
   localparam logic [2:0] REG_INV_STIFF = 3'd3;
   localparam logic [2:0] REG_KP        = 3'd4;
   localparam logic [2:0] REG_KI        = 3'd5;
   localparam logic [2:0] REG_PERIOD    = 3'd6;
   localparam logic [2:0] REG_INV_PER   = 3'd7;

   typedef logic signed [31:0] word_type;

   function automatic word_type sat64(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      else if (v < -66'sd2147483648) return 32'sh80000000;
      else return v[31:0];
   endfunction
endpackage
`default_nettype wire

/* design/contact_gated_pi_force_control_top.sv */
// ----------------------------------------------------------------------------
// contact_gated_pi_force_control_top
// contact detection, trajectory time and pi force law, shift-add multiplier
// ----------------------------------------------------------------------------
// a control tick runs 5 products of 32 serial steps plus 1 post step each,
// then writes the result; restart and transition items update state in idle
// and give no result; a stalled result holds the input
// one item at a time; the bit-serial shift-add multiplier sets the rate
// reset (synchronous, active high) clears state and loads register defaults
`default_nettype none
module contact_gated_pi_force_control_top #(
   parameter int FRACTION_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_op,
   input  wire  signed [31:0] req_force_sample,
   input  wire  signed [31:0] req_joint_position,
   input  wire         req_advance_time,
   input  wire  [31:0] req_start_time,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic signed [31:0] rsp_desired_position,
   output logic signed [31:0] rsp_desired_velocity,
   output logic [1:0]  rsp_contact_state,
   output logic [31:0] rsp_trajectory_time,
   output logic signed [31:0] rsp_transition_offset,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [4:0]  paddr,
   input  wire  [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import cgpi_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_POST = 3'd2;
   localparam logic [2:0] ST_OUT  = 3'd3;

   localparam logic [1:0] PH_D    = 2'd0;
   localparam logic [1:0] PH_STEP = 2'd1;
   localparam logic [1:0] PH_PI   = 2'd2;
   localparam logic [1:0] PH_VEL  = 2'd3;

   logic [30:0] thr_ff;
   word_type tgt_ff, ilim_ff, istf_ff, kp_ff, ki_ff;
   logic [30:0] per_ff, iper_ff;

   logic [1:0] mode_ff;
   word_type pforce_ff, integ_ff, ptgt_ff, trans_ff, d_ff;
   // proportional term kept at full width after the floor shift
   logic signed [65:0] pterm_ff;
   logic [31:0] time_ff;

   logic [2:0] state_ff;
   logic [1:0] phase_ff, sub_ff;
   logic [4:0] cnt_ff;
   word_type pos_ff;
   // serial multiplier: multiplicand, multiplier shifted right, accumulator
   logic signed [32:0] mcand_ff;
   logic signed [32:0] mplier_ff;
   logic signed [65:0] acc_ff;

   word_type o_des_ff, o_vel_ff, o_off_ff;
   logic [1:0] o_mode_ff;
   logic [31:0] o_time_ff;
   logic o_valid_ff;

   logic wr;
   logic [2:0] ridx;
   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;
   assign ridx = paddr[4:2];

   always_comb begin
      unique case (ridx)
         REG_THRESHOLD: prdata = {1'b0, thr_ff};
         REG_TARGET:    prdata = tgt_ff;
         REG_ILIMIT:    prdata = ilim_ff;
         REG_INV_STIFF: prdata = istf_ff;
         REG_KP:        prdata = kp_ff;
         REG_KI:        prdata = ki_ff;
         REG_PERIOD:    prdata = {1'b0, per_ff};
         REG_INV_PER:   prdata = {1'b0, iper_ff};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0; tgt_ff <= '0; ilim_ff <= '0; istf_ff <= 32'sd65536;
         kp_ff <= '0; ki_ff <= '0; per_ff <= 31'd655; iper_ff <= 31'd6553600;
      end else if (wr) begin
         unique case (ridx)
            REG_THRESHOLD: thr_ff <= pwdata[30:0];
            REG_TARGET:    tgt_ff <= pwdata;
            REG_ILIMIT:    ilim_ff <= pwdata;
            REG_INV_STIFF: istf_ff <= pwdata;
            REG_KP:        kp_ff <= pwdata;
            REG_KI:        ki_ff <= pwdata;
            REG_PERIOD:    per_ff <= pwdata[30:0];
            REG_INV_PER:   iper_ff <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   logic accept;
   assign req_stall = (state_ff != ST_IDLE) || (o_valid_ff && rsp_stall);
   assign accept = req_valid && !req_stall;

   // floor shift of a finished product, then saturate
   word_type prod_sat;
   logic signed [65:0] prod_sh;
   assign prod_sh = acc_ff >>> FRACTION_BITS;
   assign prod_sat = sat64(prod_sh);

   logic [32:0] amag, bmag;
   logic signed [65:0] e_wide, integ_sum, c_sum, des_sum, diff, off_wide;
   word_type e_val, integ_new, c_val, des_val;
   logic [1:0] mode_new;
   assign amag = pforce_ff[31] ? 33'(-$signed({pforce_ff[31], pforce_ff}))
                               : {1'b0, pforce_ff};
   assign bmag = req_force_sample[31]
      ? 33'(-$signed({req_force_sample[31], req_force_sample}))
      : {1'b0, req_force_sample};
   assign e_wide = 66'(tgt_ff) - 66'(req_force_sample);
   assign e_val = sat64(e_wide);
   assign off_wide = 66'(trans_ff) - 66'(req_joint_position);
   always_comb begin
      mode_new = mode_ff;
      if (amag <= 33'(thr_ff) && bmag > 33'(thr_ff)) mode_new = MODE_GOT;
      else if (amag > 33'(thr_ff) && bmag > 33'(thr_ff)) mode_new = MODE_IN;
   end
   assign integ_sum = 66'(integ_ff) + 66'(prod_sat);
   assign integ_new = (integ_sum > 66'(ilim_ff)) ? ilim_ff : sat64(integ_sum);
   assign c_sum = (pterm_ff <<< FRACTION_BITS) + acc_ff;
   assign c_val = sat64((c_sum >>> FRACTION_BITS));
   assign des_sum = 66'(pos_ff) + 66'(c_val);
   assign des_val = sat64(des_sum);
   assign diff = 66'(des_val) - 66'(ptgt_ff);

   logic signed [65:0] addend;
   assign addend = mplier_ff[0] ? 66'(mcand_ff) : 66'sd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; o_valid_ff <= 1'b0;
         mode_ff <= MODE_NONE; pforce_ff <= '0; integ_ff <= '0;
         ptgt_ff <= '0; time_ff <= '0; trans_ff <= '0;
      end else begin
         if (state_ff == ST_OUT && (!o_valid_ff || !rsp_stall)) o_valid_ff <= 1'b1;
         else if (o_valid_ff && !rsp_stall) o_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (accept) begin
               case (req_op)
                  OP_RESTART: begin
                     mode_ff <= MODE_NONE; pforce_ff <= '0; integ_ff <= '0;
                     ptgt_ff <= '0; trans_ff <= '0; time_ff <= req_start_time;
                  end
                  OP_MARK: trans_ff <= req_joint_position;
                  OP_TICK: begin
                     mode_ff <= mode_new;
                     if (mode_new == MODE_NONE || req_advance_time)
                        time_ff <= time_ff + {1'b0, per_ff};
                     pforce_ff <= req_force_sample;
                     pos_ff <= req_joint_position;
                     o_off_ff <= sat64(off_wide);
                     mcand_ff <= 33'(e_val);
                     mplier_ff <= 33'(istf_ff);
                     acc_ff <= '0;
                     cnt_ff <= '0; phase_ff <= PH_D; sub_ff <= '0;
                     state_ff <= ST_MUL;
                  end
                  default: ;
               endcase
            end
            ST_MUL: begin
               // multiplier taken as two's complement: top bit weight negative
               if (cnt_ff == 5'd31)
                  acc_ff <= acc_ff - (addend <<< 31);
               else
                  acc_ff <= acc_ff + (addend <<< cnt_ff);
               mplier_ff <= mplier_ff >>> 1;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) state_ff <= ST_POST;
            end
            ST_POST: begin
               cnt_ff <= '0;
               state_ff <= ST_MUL;
               unique case (phase_ff)
                  PH_D: begin
                     d_ff <= prod_sat;
                     mcand_ff <= 33'(prod_sat); mplier_ff <= {2'b00, per_ff};
                     acc_ff <= '0; phase_ff <= PH_STEP;
                  end
                  PH_STEP: begin
                     integ_ff <= integ_new;
                     mcand_ff <= 33'(kp_ff); mplier_ff <= 33'(d_ff);
                     acc_ff <= '0; phase_ff <= PH_PI; sub_ff <= '0;
                  end
                  PH_PI: begin
                     if (sub_ff == 2'd0) begin
                        pterm_ff <= prod_sh;
                        mcand_ff <= 33'(ki_ff); mplier_ff <= 33'(integ_ff);
                        acc_ff <= '0; sub_ff <= 2'd1;
                     end else begin
                        o_des_ff <= des_val;
                        ptgt_ff <= des_val;
                        mcand_ff <= diff[32:0];
                        mplier_ff <= {2'b00, iper_ff};
                        acc_ff <= '0; phase_ff <= PH_VEL;
                     end
                  end
                  PH_VEL: begin
                     o_vel_ff <= prod_sat;
                     state_ff <= ST_OUT;
                  end
                  default: ;
               endcase
            end
            ST_OUT: if (!o_valid_ff || !rsp_stall) begin
               o_mode_ff <= mode_ff; o_time_ff <= time_ff;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_desired_position = o_des_ff;
   assign rsp_desired_velocity = o_vel_ff;
   assign rsp_contact_state = o_mode_ff;
   assign rsp_trajectory_time = o_time_ff;
   assign rsp_transition_offset = o_off_ff;

`include "contact_gated_pi_force_control_top_assert.svh"
   `CGPI_ASSERT_IMP(a_busy_stall, clock, reset, state_ff != ST_IDLE, req_stall, "busy not stalled")
   `CGPI_ASSERT_IMP(a_mode_range, clock, reset, 1'b1, mode_ff != 2'd3, "bad contact mode")
   `CGPI_ASSERT_NEXT(a_out_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_desired_position), "result dropped")
endmodule
`default_nettype wire
